@@ hw/rtl/bli_pkg.sv @@
// Package for the bilinear interpolator: opcodes, control sideband types, latency helper.
package bli_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_BILINEAR = 2'd0,
		OP_ANGLE    = 2'd1,
		OP_DIST     = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	// sideband that rides alongside the first pair of linear stages
	typedef struct packed {
		logic [1:0] op;
		logic       zs;
	} ctl_t;

	// sideband that rides alongside the final linear stage
	typedef struct packed {
		ctl_t ctl;
		logic sat_a;
		logic sat_b;
	} ctl2_t;

	// latency of one bli_lerp unit: 5 arithmetic stages, divide setup,
	// one stage per quotient bit, saturation stage
	function automatic int lerp_lat(input int w);
		return w + 7;
	endfunction

endpackage

@@ hw/rtl/bli_lerp.sv @@
// Pipelined linear stage: ((c2-c)*qa + (c-c1)*qb)/(c2-c1), truncating, saturated.
module bli_lerp #(
	parameter int W = bli_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] c1,
	input  logic signed [W-1:0] c2,
	input  logic signed [W-1:0] c,
	input  logic signed [W-1:0] qa,
	input  logic signed [W-1:0] qb,
	output logic                out_valid,
	output logic signed [W-1:0] out_value,
	output logic                out_sat
);

	localparam int H  = W / 2;
	localparam int HI = W - H;
	localparam int NW = 2 * W + 1;

	// weights and span, sign-magnitude
	logic [W:0]   wa, wb, den;
	logic [W:0]   mwa, mwb, mden;
	logic [W-1:0] mqa, mqb;

	always_comb begin
		wa   = {c2[W-1], c2} - {c[W-1], c};
		wb   = {c[W-1], c} - {c1[W-1], c1};
		den  = {c2[W-1], c2} - {c1[W-1], c1};
		mwa  = wa[W] ? -wa : wa;
		mwb  = wb[W] ? -wb : wb;
		mden = den[W] ? -den : den;
		mqa  = qa[W-1] ? -qa : qa;
		mqb  = qb[W-1] ? -qb : qb;
	end

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [W:0]        mwa_s1, mwb_s1;
	logic [W-1:0]      mqa_s1, mqb_s1;
	logic              na_s1, nb_s1, na_s2, nb_s2, na_s3, nb_s3;
	logic [W:0]        md_s1, md_s2, md_s3, md_s4, md_s5;
	logic              dn_s1, dn_s2, dn_s3, dn_s4;
	logic [W+H:0]      pal_s2, pbl_s2;
	logic [W+HI:0]     pah_s2, pbh_s2;
	logic [NW-1:0]     ma_s3, mb_s3;
	logic signed [NW:0] num_s4;
	logic [NW-1:0]     nmag_s5;
	logic              neg_s5;

	logic [NW:0] ea, eb, sa, sb;

	always_comb begin
		ea = {1'b0, ma_s3};
		eb = {1'b0, mb_s3};
		sa = na_s3 ? -ea : ea;
		sb = nb_s3 ? -eb : eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: magnitudes and signs
		mwa_s1 <= mwa;
		mwb_s1 <= mwb;
		mqa_s1 <= mqa;
		mqb_s1 <= mqb;
		na_s1  <= wa[W] ^ qa[W-1];
		nb_s1  <= wb[W] ^ qb[W-1];
		md_s1  <= mden;
		dn_s1  <= den[W];
		// s2: half-width partial products
		pal_s2 <= mwa_s1 * mqa_s1[H-1:0];
		pah_s2 <= mwa_s1 * mqa_s1[W-1:H];
		pbl_s2 <= mwb_s1 * mqb_s1[H-1:0];
		pbh_s2 <= mwb_s1 * mqb_s1[W-1:H];
		na_s2  <= na_s1;
		nb_s2  <= nb_s1;
		md_s2  <= md_s1;
		dn_s2  <= dn_s1;
		// s3: full products
		ma_s3  <= NW'(pal_s2) + (NW'(pah_s2) << H);
		mb_s3  <= NW'(pbl_s2) + (NW'(pbh_s2) << H);
		na_s3  <= na_s2;
		nb_s3  <= nb_s2;
		md_s3  <= md_s2;
		dn_s3  <= dn_s2;
		// s4: signed numerator
		num_s4 <= sa + sb;
		md_s4  <= md_s3;
		dn_s4  <= dn_s3;
		// s5: numerator magnitude, quotient sign
		nmag_s5 <= num_s4[NW] ? NW'(-num_s4) : NW'(num_s4);
		neg_s5  <= num_s4[NW] ^ dn_s4;
		md_s5   <= md_s4;
	end

	// restoring division, one quotient bit per stage; index 0 is the setup
	logic          v_sd   [0:W];
	logic [W:0]    rem_sd [0:W];
	logic [W-1:0]  nlo_sd [0:W];
	logic [W-1:0]  quo_sd [0:W];
	logic [W:0]    md_sd  [0:W];
	logic          neg_sd [0:W];
	logic          ovf_sd [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else begin
			v_sd[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		rem_sd[0] <= nmag_s5[NW-1:W];
		ovf_sd[0] <= (nmag_s5[NW-1:W] >= md_s5);
		nlo_sd[0] <= nmag_s5[W-1:0];
		quo_sd[0] <= '0;
		md_sd[0]  <= md_s5;
		neg_sd[0] <= neg_s5;
	end

	for (genvar k = 1; k <= W; k++) begin : g_div
		logic [W+1:0] t, d;
		logic         ge;

		always_comb begin
			t  = {rem_sd[k-1], nlo_sd[k-1][W-1]};
			d  = {1'b0, md_sd[k-1]};
			ge = (t >= d);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else begin
				v_sd[k] <= v_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[k] <= ge ? (W+1)'(t - d) : t[W:0];
			quo_sd[k] <= {quo_sd[k-1][W-2:0], ge};
			nlo_sd[k] <= nlo_sd[k-1] << 1;
			md_sd[k]  <= md_sd[k-1];
			neg_sd[k] <= neg_sd[k-1];
			ovf_sd[k] <= ovf_sd[k-1];
		end
	end

	// saturation and sign
	logic [W-1:0] lim, mag;
	logic         clamp;

	always_comb begin
		lim   = neg_sd[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		clamp = ovf_sd[W] | (quo_sd[W] > lim);
		mag   = clamp ? lim : quo_sd[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_sd[W];
		end
	end

	always_ff @(posedge clk) begin
		out_value <= neg_sd[W] ? -mag : mag;
		out_sat   <= clamp;
	end

endmodule

@@ hw/rtl/bilinear_interpolator.sv @@
// Top level of the bilinear interpolator: three pipelined linear stages and sideband delay lines.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  command | start, busy          | opcode, dist_lo/hi, angle_lo/hi, val_*, query_*
//  result  | done (one-cycle)     | result, zero_span, saturated
//
//  A transaction is taken whenever start is high; busy is held low, one transaction
//  per cycle may enter. Each command passes through two linear units in series, each
//  with a restoring divider of one quotient bit per stage, and then the output
//  registers. Results leave in command order. The receiver cannot stall, so the
//  pipeline never holds. Reset clears the valid bits only; data registers are not
//  reset.
module bilinear_interpolator #(
	parameter int VALUE_WIDTH = bli_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic signed [VALUE_WIDTH-1:0] dist_lo,
	input  logic signed [VALUE_WIDTH-1:0] dist_hi,
	input  logic signed [VALUE_WIDTH-1:0] angle_lo,
	input  logic signed [VALUE_WIDTH-1:0] angle_hi,
	input  logic signed [VALUE_WIDTH-1:0] val_ll,
	input  logic signed [VALUE_WIDTH-1:0] val_hl,
	input  logic signed [VALUE_WIDTH-1:0] val_lh,
	input  logic signed [VALUE_WIDTH-1:0] val_hh,
	input  logic signed [VALUE_WIDTH-1:0] query_dist,
	input  logic signed [VALUE_WIDTH-1:0] query_angle,
	output logic                          done,
	output logic signed [31:0]            result,
	output logic                          zero_span,
	output logic                          saturated
);

	import bli_pkg::*;

	localparam int W   = VALUE_WIDTH;
	localparam int L   = lerp_lat(VALUE_WIDTH);
	localparam int LAT = 2 * L + 1;
	localparam int XW  = (W > 32) ? W : 32;

	// fully pipelined: never refuses a command
	assign busy = 1'b0;

	logic in_fire;
	assign in_fire = start & ~busy;

	// zero-span check and first-unit coordinate select
	logic                zs_in;
	logic signed [W-1:0] a_c1, a_c2, a_c;

	always_comb begin
		zs_in = 1'b0;
		a_c1  = dist_lo;
		a_c2  = dist_hi;
		a_c   = query_dist;
		case (op_t'(opcode))
			OP_BILINEAR: zs_in = (dist_lo == dist_hi) || (angle_lo == angle_hi);
			OP_ANGLE: begin
				zs_in = (angle_lo == angle_hi);
				a_c1  = angle_lo;
				a_c2  = angle_hi;
				a_c   = query_angle;
			end
			OP_DIST:  zs_in = (dist_lo == dist_hi);
			default:  zs_in = 1'b0;
		endcase
	end

	// unit A: distance stage on the lower row (or the single linear stage)
	// unit B: distance stage on the upper row (bilinear only)
	logic                a_valid, b_valid;
	logic signed [W-1:0] a_value, b_value;
	logic                a_sat, b_sat;

	bli_lerp #(.W(W)) u_lerp_a (
		.clk(clk), .arst_n(arst_n), .in_valid(in_fire),
		.c1(a_c1), .c2(a_c2), .c(a_c), .qa(val_ll), .qb(val_hl),
		.out_valid(a_valid), .out_value(a_value), .out_sat(a_sat)
	);

	bli_lerp #(.W(W)) u_lerp_b (
		.clk(clk), .arst_n(arst_n), .in_valid(in_fire),
		.c1(dist_lo), .c2(dist_hi), .c(query_dist), .qa(val_lh), .qb(val_hh),
		.out_valid(b_valid), .out_value(b_value), .out_sat(b_sat)
	);

	// sideband alongside units A and B
	ctl_t                ctl_d1 [0:L-1];
	logic signed [W-1:0] y1_d1  [0:L-1];
	logic signed [W-1:0] y2_d1  [0:L-1];
	logic signed [W-1:0] y_d1   [0:L-1];

	always_ff @(posedge clk) begin
		ctl_d1[0] <= '{op: opcode, zs: zs_in};
		y1_d1[0]  <= angle_lo;
		y2_d1[0]  <= angle_hi;
		y_d1[0]   <= query_angle;
		for (int k = 1; k < L; k++) begin
			ctl_d1[k] <= ctl_d1[k-1];
			y1_d1[k]  <= y1_d1[k-1];
			y2_d1[k]  <= y2_d1[k-1];
			y_d1[k]   <= y_d1[k-1];
		end
	end

	// unit C: angle stage for bilinear; otherwise a pass of A's value over span 0..1
	logic                bil;
	logic signed [W-1:0] c_c1, c_c2, c_c;

	always_comb begin
		bil  = (ctl_d1[L-1].op == OP_BILINEAR);
		c_c1 = bil ? y1_d1[L-1] : '0;
		c_c2 = bil ? y2_d1[L-1] : W'(1);
		c_c  = bil ? y_d1[L-1]  : '0;
	end

	logic                c_valid;
	logic signed [W-1:0] c_value;
	logic                c_sat;

	bli_lerp #(.W(W)) u_lerp_c (
		.clk(clk), .arst_n(arst_n), .in_valid(a_valid),
		.c1(c_c1), .c2(c_c2), .c(c_c), .qa(a_value), .qb(b_value),
		.out_valid(c_valid), .out_value(c_value), .out_sat(c_sat)
	);

	// sideband alongside unit C
	ctl2_t ctl_d2 [0:L-1];

	always_ff @(posedge clk) begin
		ctl_d2[0] <= '{ctl: ctl_d1[L-1], sat_a: a_sat, sat_b: b_sat};
		for (int k = 1; k < L; k++) begin
			ctl_d2[k] <= ctl_d2[k-1];
		end
	end

	// result assembly
	ctl2_t          fin;
	logic           ok, sat_any;
	logic [XW-1:0]  cext;

	always_comb begin
		fin  = ctl_d2[L-1];
		cext = XW'(c_value);
		ok   = !fin.ctl.zs && (op_t'(fin.ctl.op) != OP_UNUSED);
		case (op_t'(fin.ctl.op))
			OP_BILINEAR: sat_any = fin.sat_a | fin.sat_b | c_sat;
			OP_ANGLE:    sat_any = fin.sat_a;
			OP_DIST:     sat_any = fin.sat_a;
			default:     sat_any = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		result    <= ok ? cext[31:0] : '0;
		zero_span <= fin.ctl.zs;
		saturated <= ok & sat_any;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ##LAT done)
		else $error("command without result at fixed latency");

	a_units_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid == b_valid) && (!c_valid || $past(a_valid, L)))
		else $error("linear units out of step");

	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_span |-> (result == 32'sd0) && !saturated)
		else $error("zero span result not cleared");
`endif

endmodule
